@@ src/sliding_window_rate_limiter_defines.svh @@
// ---------------------------------------------------------------------------
// sliding_window_rate_limiter_defines.svh
// Assertion macros shared by the rate limiter RTL.
// ---------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_RATE_LIMITER_DEFINES_SVH
`define SLIDING_WINDOW_RATE_LIMITER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SWRL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SWRL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/swrl_pkg.sv @@
// ---------------------------------------------------------------------------
// swrl_pkg
// Types shared by the sliding window rate limiter.
// ---------------------------------------------------------------------------
package swrl_pkg;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_CHECK
    } t_state;

endpackage

@@ src/swrl_ram.sv @@
// ---------------------------------------------------------------------------
// swrl_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
module swrl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    i_clk,
    i_we,
    i_waddr,
    i_wdata,
    i_raddr,
    o_rdata
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    input  logic             i_clk;
    input  logic             i_we;
    input  logic [AW-1:0]    i_waddr;
    input  logic [WIDTH-1:0] i_wdata;
    input  logic [AW-1:0]    i_raddr;
    output logic [WIDTH-1:0] o_rdata;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/sliding_window_rate_limiter.sv @@
// ---------------------------------------------------------------------------
// sliding_window_rate_limiter
// Sliding-window log rate limiter: keeps a ring of accepted event stamps in
// a RAM, expires old stamps from the head, refuses events when full.
// ---------------------------------------------------------------------------
//
//  channel   | handshake                | payload
//  ----------+--------------------------+----------------------------
//  event in  | start / busy             | i_now_ticks[31:0]
//  result    | o_strobe (one cycle)     | o_too_many
//  config    | i_cfg_we                 | i_cfg_wdata[30:0] (window)
//
//  An event is accepted in IDLE, then CHECK tests the head once per stored
//  stamp it expires and once more; each test waits on the registered RAM read.
//  The result word appears on the cycle after the decision; a new event can
//  be taken on that same cycle.
//  Reset is synchronous, active low; head and count clear at once, the RAM
//  holds no reset and needs no clearing pass. The receiver cannot stall.
//
`include "sliding_window_rate_limiter_defines.svh"

module sliding_window_rate_limiter #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_now_ticks,
    output logic        o_strobe,
    output logic        o_too_many,
    input  logic        i_cfg_we,
    input  logic [30:0] i_cfg_wdata
);
    import swrl_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;  // ring index width
    localparam int CW = $clog2(DEPTH + 1);                // count width, 0..DEPTH
    localparam int TW = CW + 1;                           // tail sum width

    // Control state
    t_state          r_state, n_state;
    logic [IW-1:0]   r_head, n_head;
    logic [CW-1:0]   r_count, n_count;
    logic            r_strobe, n_strobe;
    logic [30:0]     r_window;

    // Payload registers of the event at work
    logic [31:0]     r_now;
    logic [31:0]     r_limit;
    logic            r_too_many, n_too_many;

    // RAM ports
    logic            ram_we;
    logic [IW-1:0]   ram_waddr;
    logic [IW-1:0]   ram_raddr;
    logic [31:0]     ram_rdata;

    logic            accept;
    logic            expired;
    logic            full;
    logic            finish;
    logic [31:0]     age_diff;
    logic [IW-1:0]   head_next;
    logic [TW-1:0]   tail_sum;
    logic [TW-1:0]   tail_wrap;

    assign accept = start && (r_state == ST_IDLE);
    assign busy   = (r_state != ST_IDLE);

    // Age test: stamp is strictly older than the limit when the modular
    // difference has its sign bit set. An empty ring never expires.
    assign age_diff = ram_rdata - r_limit;
    assign expired  = (r_count != '0) && age_diff[31];
    assign full     = (r_count == CW'(DEPTH));
    assign finish   = (r_state == ST_CHECK) && !expired;

    // Advance the head with wrap at the ring end.
    assign head_next = (r_head == IW'(DEPTH - 1)) ? '0 : r_head + 1'b1;

    // Tail = head + count, folded back into the ring.
    assign tail_sum  = TW'(r_head) + TW'(r_count);
    assign tail_wrap = (tail_sum >= TW'(DEPTH)) ? tail_sum - TW'(DEPTH) : tail_sum;

    swrl_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_now),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!expired) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs and datapath control
    always_comb begin
        n_head     = r_head;
        n_count    = r_count;
        n_strobe   = 1'b0;
        n_too_many = r_too_many;
        ram_we     = 1'b0;
        ram_waddr  = tail_wrap[IW-1:0];
        ram_raddr  = r_head;
        unique case (r_state)
            ST_IDLE: begin
                // Prefetch the oldest stamp; it lands as the event enters CHECK.
                ram_raddr = r_head;
            end
            ST_CHECK: begin
                if (expired) begin
                    // Drop the head stamp and fetch the next one.
                    n_head    = head_next;
                    n_count   = r_count - 1'b1;
                    ram_raddr = head_next;
                end else begin
                    n_strobe   = 1'b1;
                    n_too_many = full;
                    if (!full) begin
                        // Append at the tail.
                        ram_we  = 1'b1;
                        n_count = r_count + 1'b1;
                    end
                end
            end
            default: begin
                ram_raddr = r_head;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_strobe <= 1'b0;
            r_window <= 31'd1000;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_count  <= n_count;
            r_strobe <= n_strobe;
            if (i_cfg_we) begin
                r_window <= i_cfg_wdata;
            end
        end
    end

    // Payload registers: latch the event stamp and its expiry limit.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_now   <= i_now_ticks;
            r_limit <= i_now_ticks - {1'b0, r_window};
        end
        r_too_many <= n_too_many;
    end

    assign o_strobe   = r_strobe;
    assign o_too_many = r_too_many;

    // Assertions
    `SWRL_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH), "count exceeds depth")
    `SWRL_ASSERT_IMP(a_no_write_full, i_clk, i_rst_n, ram_we, !full && finish, "append into full ring")
    `SWRL_ASSERT_NEXT(a_strobe_after_finish, i_clk, i_rst_n, finish, r_strobe, "missing result strobe")
    `SWRL_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, accept, busy && !r_strobe, "accept not held busy")
    `SWRL_ASSERT_IMP(a_expire_nonempty, i_clk, i_rst_n, expired, r_count != '0, "expiry on empty ring")

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// Sliding window rate limiter testbench
// Streams timestamped events into the limiter through the start/busy
// handshake, keeps a shadow ring of accepted stamps to predict each refusal
// flag, and checks every result word as it strobes out. Runs a directed
// set first, then random phases over several window settings and idle rates.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RESET_CYCLES = 9;
    localparam int PHASE_WORDS = 150;
    localparam int MAX_REPORTS = 10;
    localparam logic [30:0] WINDOW_AT_RESET = 31'd1000;
    localparam logic [30:0] WINDOW_MAX = 31'h7FFF_FFFF;

    // DUT pins; the inputs are all known from time zero
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [31:0] i_now_ticks = '0;
    logic        o_strobe;
    logic        o_too_many;
    logic        i_cfg_we = 1'b0;
    logic [30:0] i_cfg_wdata = '0;

    // Event times waiting to be sent; the front is the word on the pins
    logic [31:0] event_times[$];
    // Refusal flags predicted for accepted words, oldest first
    logic        refusal_expected[$];
    logic        word_taken = 1'b0;
    int          send_idle_pct = 0;

    // Shadow copy of the limiter state
    logic [31:0] shadow_stamps[RING_DEPTH];
    int          shadow_head = 0;
    int          shadow_count = 0;
    logic [30:0] shadow_window = WINDOW_AT_RESET;

    int          cycle_count = 0;
    int          mismatches = 0;
    int          words_sent = 0;
    int          results_checked = 0;
    int          refusals_seen = 0;
    int          window_writes = 0;

    sliding_window_rate_limiter #(
        .DEPTH(RING_DEPTH)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_now_ticks(i_now_ticks),
        .o_strobe   (o_strobe),
        .o_too_many (o_too_many),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Expire stale stamps from the head, then refuse when the ring is still
    // full or append the new stamp at the tail. A stamp exactly at the limit
    // survives; the modular test also covers time running backwards.
    function automatic logic predict_refusal(input logic [31:0] now);
        logic [31:0] limit;
        logic [31:0] age;
        logic        expiring;
        limit = now - {1'b0, shadow_window};
        expiring = 1'b1;
        while (expiring && shadow_count > 0) begin
            age = shadow_stamps[shadow_head] - limit;
            if (age[31]) begin
                shadow_head = (shadow_head + 1) % RING_DEPTH;
                shadow_count--;
            end else begin
                expiring = 1'b0;
            end
        end
        if (shadow_count >= RING_DEPTH) begin
            return 1'b1;
        end
        shadow_stamps[(shadow_head + shadow_count) % RING_DEPTH] = now;
        shadow_count++;
        return 1'b0;
    endfunction

    // Driver: change pins on the falling edge. Hold start while a word waits
    // on busy; once it is taken, present the next one or idle at random.
    always @(negedge i_clk) begin
        if (!start || word_taken) begin
            if (i_rst_n && event_times.size() != 0 &&
                    $urandom_range(99) >= send_idle_pct) begin
                start <= 1'b1;
                i_now_ticks <= event_times[0];
            end else begin
                start <= 1'b0;
                i_now_ticks <= $urandom;
            end
        end
    end

    // Monitor: on the rising edge, record an accepted word and predict its
    // result, then check any result word strobed in this cycle.
    always @(posedge i_clk) begin
        word_taken <= i_rst_n && start && !busy;
        if (i_rst_n && start && !busy) begin
            void'(event_times.pop_front());
            refusal_expected.push_back(predict_refusal(i_now_ticks));
            words_sent++;
        end
        if (i_rst_n && o_strobe) begin
            if (refusal_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("ERROR: result word with none expected, too_many=%0b",
                             o_too_many);
                end
            end else begin
                logic want;
                want = refusal_expected.pop_front();
                results_checked++;
                if (o_too_many) begin
                    refusals_seen++;
                end
                if (o_too_many !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("ERROR: result %0d too_many expected %0b, got %0b",
                                 results_checked, want, o_too_many);
                    end
                end
            end
        end
    end

    // Watchdog: stop a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("ERROR: cycle limit reached with %0d words outstanding",
                     event_times.size() + refusal_expected.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Block until every queued word is taken and every result has come back.
    task automatic wait_drained();
        while (event_times.size() != 0 || refusal_expected.size() != 0 || busy) begin
            @(negedge i_clk);
        end
    endtask

    // Write the window register; only called while the limiter is idle.
    task automatic write_window(input logic [30:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= 31'($urandom);
        shadow_window = value;
        window_writes++;
    endtask

    // Random phase: a drifting clock mostly moving by a fraction of the
    // window so the ring fills and drains, with repeats, longer jumps,
    // backward steps and fully random stamps mixed in.
    task automatic run_random_phase(input logic [30:0] window, input int idle_pct);
        longint      w;
        logic [31:0] now;
        int          pick;
        w = longint'(window);
        if ($urandom_range(1)) begin
            now = $urandom;
        end else begin
            now = 32'hFFFF_FFFF - $urandom_range(0, 4095);
        end
        wait_drained();
        write_window(window);
        send_idle_pct = idle_pct;
        repeat (PHASE_WORDS) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                now += $urandom_range(0, int'(w / 8 + 1));
            end else if (pick < 75) begin
                now += $urandom_range(0, int'(w + w / 4));
            end else if (pick < 85) begin
                // repeat the same time
            end else if (pick < 92) begin
                now -= $urandom_range(0, int'(w / 2 + 1));
            end else begin
                now = $urandom;
            end
            event_times.push_back(now);
        end
    endtask

    logic [30:0] phase_windows[9];

    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words at the reset window of 1000: fill the ring at one
        // time, overflow it, keep a stamp sitting exactly on the limit,
        // expire the whole ring, step backward, then hit the time extremes.
        send_idle_pct = 0;
        repeat (RING_DEPTH) event_times.push_back(32'd0);
        event_times.push_back(32'd0);
        event_times.push_back(32'd1000);
        event_times.push_back(32'd1001);
        event_times.push_back(32'd500);
        event_times.push_back(32'hFFFF_FFFF);
        event_times.push_back(32'h8000_0000);
        event_times.push_back(32'h7FFF_FFFF);
        event_times.push_back(32'h0000_0000);

        // Random phases: sender idles 35 percent, then 68, then not at all,
        // sweeping the window through both extremes and assorted sizes.
        phase_windows = '{31'd20, 31'd0, 31'd400, WINDOW_MAX, 31'd3,
                          WINDOW_AT_RESET, 31'd0, WINDOW_MAX, 31'($urandom)};
        for (int p = 0; p < 9; p++) begin
            run_random_phase(phase_windows[p], (p < 3) ? 35 : (p < 6) ? 68 : 0);
        end

        wait_drained();
        repeat (40) @(negedge i_clk);
        if (refusal_expected.size() != 0) begin
            mismatches++;
            $display("ERROR: %0d results never arrived", refusal_expected.size());
        end

        $display("Sent %0d events over %0d window settings;",
                 words_sent, window_writes + 1);
        $display("checked %0d results, %0d refused.", results_checked, refusals_seen);
        $display("Mismatches: %0d", mismatches);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ sliding_window_rate_limiter.f @@
+incdir+src
src/swrl_pkg.sv
src/swrl_ram.sv
src/sliding_window_rate_limiter.sv
bench/testbench.sv
